// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file eofv_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/eofv_pkg.sv -----
// Package for the Engquist-Osher finite-volume step: widths, payload
// structs, controller/datapath command bundles and the cosh table.
// Depends on nothing.
package eofv_pkg;

  localparam int VALUE_WIDTH      = 16;
  localparam int COSH_TABLE_DEPTH = 256;

  localparam int FRAC_BITS = VALUE_WIDTH - 4;
  localparam int RATIO_W   = 24;
  localparam int COSH_W    = 24;            // cosh in unsigned Q.12, up to cosh(8)
  localparam int FLUX_W    = COSH_W + 1;    // cosh(v) + cosh(w) - cosh(0)
  localparam int DIFF_W    = FLUX_W + 1;
  localparam int IDX_W     = $clog2(COSH_TABLE_DEPTH + 1);
  localparam int FR_W      = VALUE_WIDTH - 1;
  localparam int S_W       = FR_W + IDX_W;
  localparam int MUL_A_W   = FLUX_W;
  localparam int MUL_B_W   = (RATIO_W > FR_W) ? RATIO_W : FR_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int PROD_SHIFT = 28 - FRAC_BITS;
  localparam int M_W       = PROD_W + 1;
  localparam int R_W       = M_W + 2;

  localparam logic [M_W-1:0] ROUND_HALF = M_W'((64'd1 << PROD_SHIFT) >> 1);
  localparam logic signed [R_W-1:0] VMAX_R =
    R_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [R_W-1:0] VMIN_R = -VMAX_R - R_W'(1);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] cell_value;
    logic                          first_cell;
    logic                          last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic                          is_last;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic rd_lo;
    logic rd_hi;
    logic mul_interp;
    logic calc_cosh;
    logic prep_mid;
    logic prep_end;
    logic mul_upd;
    logic round;
    logic emit;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic pend;      // a left neighbor is waiting for its update
    logic last;      // current cell closes the grid
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

  typedef logic [COSH_W-1:0] cosh_tab_t [0:COSH_TABLE_DEPTH];

  // cosh(x_k) by Taylor series in Q.20, rounded to Q.12. Elaboration only.
  function automatic cosh_tab_t build_cosh_tab();
    cosh_tab_t   tab;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    for (int k = 0; k <= COSH_TABLE_DEPTH; k++) begin
      x    = (64'(k) << 23) / 64'(COSH_TABLE_DEPTH);
      sum  = 64'd1 << 20;
      term = 64'd1 << 20;
      done = 1'b0;
      for (int n = 1; n <= 40; n++) begin
        if (!done) begin
          term = (term * x) >> 20;
          term = (term * x) >> 20;
          term = term / 64'((2 * n - 1) * (2 * n));
          if (term == 64'd0) begin
            done = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[k] = COSH_W'((sum + 64'd128) >> 8);
    end
    return tab;
  endfunction

  localparam cosh_tab_t COSH_TAB = build_cosh_tab();
  localparam logic [COSH_W-1:0] COSH_ZERO = COSH_TAB[0];

endpackage

// ----- rtl/core/eofv_ctrl.sv -----
// Sequencer for the finite-volume step: walks one cell through table
// lookup, interpolation and up to two flux updates. Uses eofv_pkg.
module eofv_ctrl import eofv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_LO     = 10'b00_0000_0010,
    S_HI     = 10'b00_0000_0100,
    S_INTERP = 10'b00_0000_1000,
    S_CALC   = 10'b00_0001_0000,
    S_PREP   = 10'b00_0010_0000,
    S_MUL    = 10'b00_0100_0000,
    S_RND    = 10'b00_1000_0000,
    S_EMIT   = 10'b01_0000_0000,
    S_COMMIT = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   end_phase, end_phase_next;   // 1: working on the last cell's own update

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      end_phase <= 1'b0;
    end else begin
      state     <= state_next;
      end_phase <= end_phase_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    end_phase_next = end_phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LO;
        end
      end
      S_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_INTERP;
      end
      S_INTERP: begin
        cmd.mul_interp = 1'b1;
        state_next     = S_CALC;
      end
      S_CALC: begin
        cmd.calc_cosh = 1'b1;
        if (status.pend) begin
          end_phase_next = 1'b0;
          state_next     = S_PREP;
        end else if (status.last) begin
          end_phase_next = 1'b1;
          state_next     = S_PREP;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_PREP: begin
        cmd.prep_mid = !end_phase;
        cmd.prep_end = end_phase;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_upd = 1'b1;
        state_next  = S_RND;
      end
      S_RND: begin
        cmd.round  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!end_phase && status.last) begin
            end_phase_next = 1'b1;
            state_next     = S_PREP;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/eofv_datapath.sv -----
// Datapath of the finite-volume step: cosh lookup and interpolation, flux
// selection, shared multiplier, rounding, saturation, output register.
// Uses eofv_pkg; driven by eofv_ctrl.
module eofv_datapath import eofv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [RATIO_W-1:0] cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output out_item_t          out_data
);

  logic [RATIO_W-1:0] step_ratio;

  // current cell
  logic signed [VALUE_WIDTH-1:0] x_r;
  logic                          first_r;
  logic                          last_r;

  // cosh evaluation
  logic [COSH_W-1:0]  lo_r, hi_r, c_r;
  logic [FR_W-1:0]    fr_r;
  logic [PROD_W-1:0]  prod_r;

  // update operands
  logic [FLUX_W-1:0]             lf_r;
  logic [FLUX_W-1:0]             dmag_r;
  logic                          neg_r;
  logic signed [VALUE_WIDTH-1:0] u_sel;
  logic                          sel_last;
  logic [M_W-1:0]                m_r;

  // pending cell
  logic signed [VALUE_WIDTH-1:0] prev_value;
  logic [COSH_W-1:0]             prev_cosh;
  logic [FLUX_W-1:0]             left_flux;
  logic                          have_prev;

  logic [VALUE_WIDTH-1:0] mag;
  logic [S_W-1:0]         s;
  logic [IDX_W-1:0]       idx, addr;
  logic                   sat;
  logic [COSH_W-1:0]      tab_q, d, c_calc;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [FLUX_W-1:0]      flux;
  logic [DIFF_W-1:0]      diff;
  logic signed [R_W-1:0]  u_ext, m_s, r;
  logic signed [VALUE_WIDTH-1:0] r_sat;

  // table index and fraction from |u| * depth
  always_comb begin
    mag = x_r[VALUE_WIDTH-1] ? VALUE_WIDTH'(-x_r) : VALUE_WIDTH'(x_r);
    s   = S_W'(mag) * S_W'(COSH_TABLE_DEPTH);
    idx = s[FR_W +: IDX_W];
    sat = (idx >= IDX_W'(COSH_TABLE_DEPTH));
    if (sat) begin
      addr = IDX_W'(COSH_TABLE_DEPTH);
    end else if (cmd.rd_hi) begin
      addr = idx + IDX_W'(1);
    end else begin
      addr = idx;
    end
    tab_q  = COSH_TAB[addr];
    d      = (hi_r >= lo_r) ? (hi_r - lo_r) : '0;
    c_calc = lo_r + COSH_W'(prod_r >> FR_W);
  end

  // shared multiplier operands
  always_comb begin
    if (cmd.mul_interp) begin
      mul_a = MUL_A_W'(d);
      mul_b = MUL_B_W'(fr_r);
    end else begin
      mul_a = dmag_r;
      mul_b = MUL_B_W'(step_ratio);
    end
  end

  // Engquist-Osher flux between pending cell (v) and current cell (w)
  always_comb begin
    unique case ({prev_value[VALUE_WIDTH-1], x_r[VALUE_WIDTH-1]})
      2'b00:   flux = FLUX_W'(prev_cosh);
      2'b10:   flux = FLUX_W'(COSH_ZERO);
      2'b01:   flux = FLUX_W'(prev_cosh) + FLUX_W'(c_r) - FLUX_W'(COSH_ZERO);
      default: flux = FLUX_W'(c_r);
    endcase
    if (cmd.prep_mid) begin
      diff = DIFF_W'(flux) - DIFF_W'(left_flux);
    end else begin
      diff = DIFF_W'(c_r) - DIFF_W'(lf_r);
    end
  end

  // u -/+ m with saturation
  always_comb begin
    u_ext = R_W'(u_sel);
    m_s   = signed'(R_W'(m_r));
    r     = neg_r ? (u_ext + m_s) : (u_ext - m_s);
    if (r > VMAX_R) begin
      r_sat = VALUE_WIDTH'(VMAX_R);
    end else if (r < VMIN_R) begin
      r_sat = VALUE_WIDTH'(VMIN_R);
    end else begin
      r_sat = VALUE_WIDTH'(r);
    end
  end

  assign status.pend     = have_prev && !first_r;
  assign status.last     = last_r;
  assign status.out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= '0;
      have_prev  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_ratio <= cfg_data;
      end
      if (cmd.commit) begin
        have_prev <= !last_r;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r     <= in_data.cell_value;
      first_r <= in_data.first_cell;
      last_r  <= in_data.last_cell;
    end
    if (cmd.rd_lo) begin
      lo_r <= tab_q;
    end
    if (cmd.rd_hi) begin
      hi_r <= tab_q;
      fr_r <= sat ? '0 : s[FR_W-1:0];
    end
    if (cmd.mul_interp || cmd.mul_upd) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.calc_cosh) begin
      c_r  <= c_calc;
      lf_r <= FLUX_W'(c_calc);
    end
    if (cmd.prep_mid || cmd.prep_end) begin
      neg_r  <= diff[DIFF_W-1];
      dmag_r <= diff[DIFF_W-1] ? FLUX_W'(-diff) : FLUX_W'(diff);
    end
    if (cmd.prep_mid) begin
      lf_r     <= flux;
      u_sel    <= prev_value;
      sel_last <= 1'b0;
    end
    if (cmd.prep_end) begin
      u_sel    <= x_r;
      sel_last <= 1'b1;
    end
    if (cmd.round) begin
      m_r <= (M_W'(prod_r) + ROUND_HALF) >> PROD_SHIFT;
    end
    if (cmd.emit) begin
      out_data.new_value <= r_sat;
      out_data.is_last   <= sel_last;
    end
    if (cmd.commit && !last_r) begin
      prev_value <= x_r;
      prev_cosh  <= c_r;
      left_flux  <= lf_r;
    end
  end

endmodule

// ----- rtl/core/engquist_osher_fv_step.sv -----
// Top level of the Engquist-Osher finite-volume step for u_t + (cosh u)_x = 0.
// Joins eofv_ctrl and eofv_datapath; uses eofv_pkg.
//
//  channel | handshake            | payload     | content
//  --------+----------------------+-------------+---------------------------------
//  in      | in_valid / in_ready  | in_item_t   | cell_value Q3.12, first/last mark
//  out     | out_valid / out_ready| out_item_t  | new_value Q3.12 saturated, is_last
//  cfg     | cfg_valid / cfg_ready| 24-bit data | step_ratio, unsigned Q8.16
//
// One cell per transaction, one cell in flight. A cell with no result passes
// through the table reads, interpolation, the cosh step and commit; each update
// it produces adds flux prep, multiply, round and emit. The single table read
// port and the multiplier shared by interpolation and the update set this order.
// A result sits in the output register until taken; an emit waits there
// while it is still full, and in_ready stays low meanwhile. Reset (rst,
// synchronous) clears step_ratio, the pending-cell flag and out_valid.
// cfg is always ready and is meant to be written while the block is idle.
module engquist_osher_fv_step import eofv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RATIO_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never stall
  assign cfg_ready = 1'b1;

  eofv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath loads the cell itself on cmd.load_in (in_valid && in_ready)
  eofv_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/eofv_checker.sv -----
// Port-level checks for engquist_osher_fv_step, bound to the top level.
// Uses eofv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eofv_checker import eofv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // register port never back-pressures
  `ASSERT_IMP(a_cfg_always_ready, clk, rst, cfg_valid, cfg_ready)

  // one cell in flight: input closes right after a transaction
  `ASSERT_NXT(a_one_cell_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a new result only appears while a cell is being worked on
  `ASSERT_IMP(a_result_while_busy, clk, rst, $rose(out_valid), !in_ready)

  // stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind engquist_osher_fv_step eofv_checker u_eofv_checker (.*);
